### hdl/ndb_pkg.sv
`default_nettype none

package ndb_pkg;

  localparam int COLUMN_BITS_DEF   = 12;
  localparam int DEPTH_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;

  // Port widths of the item fields
  localparam int DEPTH_W   = 16;
  localparam int COLUMN_W  = 12;
  localparam int RANGE_W   = 17;
  localparam int BEARING_W = 16;
  localparam int ANGLE_W   = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [RANGE_W-1:0] RANGE_CAP = '1;
  localparam logic [23:0]        INV_GAIN  = 24'd10188014;

  localparam logic signed [16:0] BEAR_HI = 17'sd16384;
  localparam logic signed [16:0] BEAR_LO = -17'sd16384;

  localparam logic [15:0] CENTER_COLUMN_RST = 16'd5120;
  localparam logic [23:0] INVERSE_FOCAL_RST = 24'd27962;
  localparam logic [15:0] MIN_RANGE_RST     = 16'd10;
  localparam logic [15:0] MAX_RANGE_RST     = 16'd10000;

  // atan(2^-i) in units of pi/2^31
  localparam logic [ANGLE_W-1:0] ARC_TABLE [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_COLUMN = 2'd0,
    REG_INVERSE_FOCAL = 2'd1,
    REG_MIN_RANGE     = 2'd2,
    REG_MAX_RANGE     = 2'd3
  } cfg_reg_t;

  // Control bits that travel with each item down the pipeline
  typedef struct packed {
    logic vld;
    logic qual;
    logic last;
  } tag_t;

endpackage

`default_nettype wire

### hdl/ndb_front.sv
`default_nettype none

module ndb_front #(
  parameter int COLUMN_BITS = ndb_pkg::COLUMN_BITS_DEF,
  parameter int DEPTH_BITS  = ndb_pkg::DEPTH_BITS_DEF,
  parameter int MAG_BITS    = 20,
  parameter int T_BITS      = 36,
  parameter int CW          = 44
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic [ndb_pkg::DEPTH_W-1:0]   pixel_depth,
  input  wire logic                          pixel_valid,
  input  wire logic [ndb_pkg::COLUMN_W-1:0]  pixel_column,
  input  wire logic                          last_pixel,
  input  wire logic [15:0]                   center_column,
  input  wire logic [23:0]                   inverse_focal,
  input  wire logic [15:0]                   min_range,
  input  wire logic [15:0]                   max_range,
  output ndb_pkg::tag_t                      tag_o,
  output logic signed [CW-1:0]               x_o,
  output logic signed [CW-1:0]               y_o
);

  localparam int CB  = COLUMN_BITS + 4;
  localparam int DCW = (DEPTH_BITS > 16) ? DEPTH_BITS : 16;
  localparam int PW  = T_BITS + 12;
  localparam int YW  = PW - 7;

  logic [DEPTH_BITS-1:0]   d;
  logic [COLUMN_BITS-1:0]  col;
  logic [CB-1:0]           colx;
  logic signed [MAG_BITS:0] diff;
  logic [MAG_BITS-1:0]     mag;
  logic                    qual;
  logic [PW:0]             sum;
  logic [YW-1:0]           ymag;

  ndb_pkg::tag_t           tag1_r, tag2_r, tag3_r, tag4_r;
  logic [DEPTH_BITS-1:0]   d1_r, d2_r, d3_r;
  logic                    flip1_r, flip2_r, flip3_r;
  logic [MAG_BITS-1:0]     mag1_r;
  logic [T_BITS-1:0]       t_r, t_nxt;
  logic [PW-1:0]           ph_r, ph_nxt, pl_r, pl_nxt;
  logic signed [CW-1:0]    x_r, x_nxt, y_r, y_nxt;

  assign d    = DEPTH_BITS'(pixel_depth);
  assign col  = COLUMN_BITS'(pixel_column);
  assign colx = {col, 4'b0000};
  assign diff = $signed({1'b0, MAG_BITS'(colx)}) - $signed({1'b0, MAG_BITS'(center_column)});
  assign mag  = diff[MAG_BITS] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
  assign qual = pixel_valid && (DCW'(d) > DCW'(min_range)) && (DCW'(d) < DCW'(max_range));

  assign t_nxt  = T_BITS'(mag1_r) * T_BITS'(d1_r);
  assign ph_nxt = PW'(t_r) * PW'(inverse_focal[23:12]);
  assign pl_nxt = PW'(t_r) * PW'(inverse_focal[11:0]);

  // round half up, 8 fraction bits kept
  assign sum  = (PW+1)'(ph_r) + (PW+1)'(pl_r >> 12) + (PW+1)'(128);
  assign ymag = sum[PW:8];
  assign y_nxt = flip3_r ? -$signed(CW'(ymag)) : $signed(CW'(ymag));
  assign x_nxt = $signed(CW'({d3_r, 8'b0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (en) begin
      tag1_r <= '{vld: in_vld, qual: qual, last: last_pixel};
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= d;
      mag1_r  <= mag;
      flip1_r <= (diff > 0);
      d2_r    <= d1_r;
      flip2_r <= flip1_r;
      t_r     <= t_nxt;
      d3_r    <= d2_r;
      flip3_r <= flip2_r;
      ph_r    <= ph_nxt;
      pl_r    <= pl_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

  assign tag_o = tag4_r;
  assign x_o   = x_r;
  assign y_o   = y_r;

endmodule

`default_nettype wire

### hdl/ndb_cordic_cell.sv
`default_nettype none

module ndb_cordic_cell #(
  parameter int CW    = 44,
  parameter int STAGE = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire ndb_pkg::tag_t                      tag_i,
  input  wire logic signed [CW-1:0]               x_i,
  input  wire logic signed [CW-1:0]               y_i,
  input  wire logic signed [ndb_pkg::ANGLE_W-1:0] z_i,
  output ndb_pkg::tag_t                           tag_o,
  output logic signed [CW-1:0]                    x_o,
  output logic signed [CW-1:0]                    y_o,
  output logic signed [ndb_pkg::ANGLE_W-1:0]      z_o
);

  localparam logic signed [ndb_pkg::ANGLE_W-1:0] ARC = $signed(ndb_pkg::ARC_TABLE[STAGE]);

  ndb_pkg::tag_t                         tag_r;
  logic signed [CW-1:0]                  dx, dy, x_r, x_nxt, y_r, y_nxt;
  logic signed [ndb_pkg::ANGLE_W-1:0]    z_r, z_nxt;

  assign dx = y_i >>> STAGE;
  assign dy = x_i >>> STAGE;

  // rotate toward the x axis
  always_comb begin
    if (y_i < 0) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ARC;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

### hdl/ndb_track.sv
`default_nettype none

module ndb_track #(
  parameter int CW = 44
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire ndb_pkg::tag_t                       tag_i,
  input  wire logic signed [CW-1:0]                x_i,
  input  wire logic signed [ndb_pkg::ANGLE_W-1:0]  z_i,
  output logic                                     out_valid,
  output logic [ndb_pkg::RANGE_W-1:0]              out_range,
  output logic signed [ndb_pkg::BEARING_W-1:0]     out_bearing,
  output logic                                     out_found
);

  localparam int RW = ndb_pkg::RANGE_W;
  localparam int BW = ndb_pkg::BEARING_W;
  localparam int AW = ndb_pkg::ANGLE_W;

  ndb_pkg::tag_t          tag_r;
  logic                   sat_r, sat_nxt;
  logic [26:0]            xs;
  logic [50:0]            prod_r, prod_nxt;
  logic signed [AW:0]     zs;
  logic signed [16:0]     b17;
  logic signed [BW-1:0]   bear_r, bear_nxt;

  logic [51:0]            rnd;
  logic [19:0]            r20;
  logic [RW-1:0]          range;
  logic                   upd;

  logic [RW-1:0]          best_r, best_nxt;
  logic signed [BW-1:0]   bbear_r, bbear_nxt;
  logic                   any_r, any_nxt;
  logic                   ov_r, ov_nxt;
  logic [RW-1:0]          orange_r, orange_nxt;
  logic signed [BW-1:0]   obear_r, obear_nxt;
  logic                   ofound_r, ofound_nxt;

  // gain correction and bearing scaling
  assign sat_nxt  = !x_i[CW-1] && (|x_i[CW-2:27]);
  assign xs       = x_i[CW-1] ? 27'd0 : x_i[26:0];
  assign prod_nxt = 51'(xs) * 51'(ndb_pkg::INV_GAIN);
  assign zs       = {z_i[AW-1], z_i} + (AW+1)'(32768);
  assign b17      = zs[AW:16];

  always_comb begin
    if (b17 > ndb_pkg::BEAR_HI) begin
      bear_nxt = BW'(ndb_pkg::BEAR_HI);
    end else if (b17 < ndb_pkg::BEAR_LO) begin
      bear_nxt = BW'(ndb_pkg::BEAR_LO);
    end else begin
      bear_nxt = BW'(b17);
    end
  end

  assign rnd   = 52'(prod_r) + (52'd1 << 31);
  assign r20   = rnd[51:32];
  assign range = (sat_r || (r20 > 20'(ndb_pkg::RANGE_CAP))) ? ndb_pkg::RANGE_CAP : r20[RW-1:0];

  // keep the nearest point; a tie goes to the later pixel
  assign upd = tag_r.vld && tag_r.qual && (!any_r || (range <= best_r));

  always_comb begin
    best_nxt   = upd ? range : best_r;
    bbear_nxt  = upd ? bear_r : bbear_r;
    any_nxt    = any_r || upd;
    ov_nxt     = tag_r.vld && tag_r.last;
    orange_nxt = any_nxt ? best_nxt : '0;
    obear_nxt  = any_nxt ? bbear_nxt : '0;
    ofound_nxt = any_nxt;
    if (tag_r.vld && tag_r.last) begin
      best_nxt  = ndb_pkg::RANGE_CAP;
      bbear_nxt = '0;
      any_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= '0;
      best_r  <= ndb_pkg::RANGE_CAP;
      bbear_r <= '0;
      any_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else if (en) begin
      tag_r   <= tag_i;
      best_r  <= best_nxt;
      bbear_r <= bbear_nxt;
      any_r   <= any_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r    <= sat_nxt;
      prod_r   <= prod_nxt;
      bear_r   <= bear_nxt;
      orange_r <= orange_nxt;
      obear_r  <= obear_nxt;
      ofound_r <= ofound_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign out_range   = orange_r;
  assign out_bearing = obear_r;
  assign out_found   = ofound_r;

endmodule

`default_nettype wire

### hdl/nearest_depth_bearing_in_box.sv
// Finds the nearest valid depth point in a detection box and its bearing. Pixels stream in one
// per clock; each one that is valid and strictly inside (min_range, max_range) gets a lateral
// offset from its column, then a chain of CORDIC cells (one cell per stage) turns depth and offset
// into planar range and bearing. The nearest point is kept, the later pixel winning a tie, and the
// box's last pixel produces one result item (range 0, bearing 0, found 0 for an empty box).
// Throughput is one pixel per clock while the pipeline is not held; from pixel to result lie
// the column difference register, two multiply stages and the offset register in front, one
// register per CORDIC cell, then the gain multiply and the tracking stage, which also registers
// the result item. The pipeline holds as a whole while a result item waits on out_stall. Write
// configuration only while no box is in flight.
`default_nettype none

module nearest_depth_bearing_in_box #(
  parameter int COLUMN_BITS   = ndb_pkg::COLUMN_BITS_DEF,
  parameter int DEPTH_BITS    = ndb_pkg::DEPTH_BITS_DEF,
  parameter int CORDIC_STAGES = ndb_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [ndb_pkg::DEPTH_W-1:0]          in_pixel_depth,
  input  wire logic                                 in_pixel_valid,
  input  wire logic [ndb_pkg::COLUMN_W-1:0]         in_pixel_column,
  input  wire logic                                 in_last_pixel,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [ndb_pkg::RANGE_W-1:0]               out_nearest_range,
  output logic signed [ndb_pkg::BEARING_W-1:0]      out_nearest_bearing,
  output logic                                      out_found,
  input  wire logic                                 cfg_we,
  input  wire logic [ndb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ndb_pkg::CFG_W-1:0]            cfg_data
);

  localparam int STAGE_COUNT = (CORDIC_STAGES > ndb_pkg::MAX_STAGES) ?
                               ndb_pkg::MAX_STAGES : CORDIC_STAGES;
  localparam int CB       = COLUMN_BITS + 4;
  localparam int MAG_BITS = (CB > 16) ? CB : 16;
  localparam int T_BITS   = MAG_BITS + DEPTH_BITS;
  localparam int CW       = T_BITS + 8;
  localparam int AW       = ndb_pkg::ANGLE_W;

  logic [15:0] center_column_r;
  logic [23:0] inverse_focal_r;
  logic [15:0] min_range_r;
  logic [15:0] max_range_r;
  logic        en;

  ndb_pkg::tag_t        tag   [STAGE_COUNT+1];
  logic signed [CW-1:0] cx    [STAGE_COUNT+1];
  logic signed [CW-1:0] cy    [STAGE_COUNT+1];
  logic signed [AW-1:0] cz    [STAGE_COUNT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_column_r <= ndb_pkg::CENTER_COLUMN_RST;
      inverse_focal_r <= ndb_pkg::INVERSE_FOCAL_RST;
      min_range_r     <= ndb_pkg::MIN_RANGE_RST;
      max_range_r     <= ndb_pkg::MAX_RANGE_RST;
    end else if (cfg_we) begin
      case (ndb_pkg::cfg_reg_t'(cfg_index))
        ndb_pkg::REG_CENTER_COLUMN: center_column_r <= cfg_data[15:0];
        ndb_pkg::REG_INVERSE_FOCAL: inverse_focal_r <= cfg_data;
        ndb_pkg::REG_MIN_RANGE:     min_range_r     <= cfg_data[15:0];
        ndb_pkg::REG_MAX_RANGE:     max_range_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // hold the whole pipeline while a result item waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ndb_front #(
    .COLUMN_BITS (COLUMN_BITS),
    .DEPTH_BITS  (DEPTH_BITS),
    .MAG_BITS    (MAG_BITS),
    .T_BITS      (T_BITS),
    .CW          (CW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_vld        (in_valid),
    .pixel_depth   (in_pixel_depth),
    .pixel_valid   (in_pixel_valid),
    .pixel_column  (in_pixel_column),
    .last_pixel    (in_last_pixel),
    .center_column (center_column_r),
    .inverse_focal (inverse_focal_r),
    .min_range     (min_range_r),
    .max_range     (max_range_r),
    .tag_o         (tag[0]),
    .x_o           (cx[0]),
    .y_o           (cy[0])
  );

  assign cz[0] = '0;

  for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_cell
    ndb_cordic_cell #(
      .CW    (CW),
      .STAGE (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tag_i (tag[i]),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .tag_o (tag[i+1]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  ndb_track #(
    .CW (CW)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .tag_i       (tag[STAGE_COUNT]),
    .x_i         (cx[STAGE_COUNT]),
    .z_i         (cz[STAGE_COUNT]),
    .out_valid   (out_valid),
    .out_range   (out_nearest_range),
    .out_bearing (out_nearest_bearing),
    .out_found   (out_found)
  );

  a_empty_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_nearest_range == '0 && out_nearest_bearing == '0)
    else $error("empty box result carries nonzero range or bearing");

  a_bearing_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_nearest_bearing <= 16'sd16384 && out_nearest_bearing >= -16'sd16384)
    else $error("bearing outside quarter turn");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_nearest_range) &&
      $stable(out_nearest_bearing) && $stable(out_found))
    else $error("waiting result item changed");

endmodule

`default_nettype wire

### dv/ndb_checker.sv
`timescale 1ns / 100ps

module ndb_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic                                in_stall,
  input  wire logic [ndb_pkg::DEPTH_W-1:0]         in_pixel_depth,
  input  wire logic                                in_pixel_valid,
  input  wire logic [ndb_pkg::COLUMN_W-1:0]        in_pixel_column,
  input  wire logic                                in_last_pixel,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic [ndb_pkg::RANGE_W-1:0]         out_nearest_range,
  input  wire logic signed [ndb_pkg::BEARING_W-1:0] out_nearest_bearing,
  input  wire logic                                out_found,
  input  wire logic                                cfg_we,
  input  wire logic [ndb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ndb_pkg::CFG_W-1:0]           cfg_data,
  output int                                       fail_count,
  output int                                       pending_count
);

  localparam int STAGES = (ndb_pkg::CORDIC_STAGES_DEF > ndb_pkg::MAX_STAGES) ?
                          ndb_pkg::MAX_STAGES : ndb_pkg::CORDIC_STAGES_DEF;
  localparam int RW = ndb_pkg::RANGE_W;
  localparam int BW = ndb_pkg::BEARING_W;

  typedef struct {
    logic [RW-1:0]        rng;
    logic signed [BW-1:0] brg;
    logic                 fnd;
  } box_result_t;

  box_result_t due_results[$];

  logic [15:0] cc_q;
  logic [23:0] inv_q;
  logic [15:0] min_q;
  logic [15:0] max_q;

  logic [RW-1:0]        best_rng;
  logic signed [BW-1:0] best_brg;
  logic                 have_point;

  logic [RW-1:0]        pt_rng;
  logic signed [BW-1:0] pt_brg;
  box_result_t          exp_res;

  // Planar range and bearing of one pixel: lateral offset, then vectoring CORDIC.
  function automatic void locate_point(input logic [15:0] d, input logic [11:0] col,
                                       output logic [RW-1:0] rng,
                                       output logic signed [BW-1:0] brg);
    longint diff, x, y, z, dx, dy;
    longint unsigned mag, t, hi, lo, ymag, r;
    diff = 64'(col) * 16 - 64'(cc_q);
    mag  = (diff < 0) ? -diff : diff;
    t    = mag * 64'(d);
    hi   = 64'(inv_q >> 12);
    lo   = 64'(inv_q & 24'hFFF);
    ymag = (t * hi + ((t * lo) >> 12) + 64'd128) >> 8;
    x    = 64'(d) << 8;
    y    = (diff > 0) ? -longint'(ymag) : longint'(ymag);
    z    = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(64'(ndb_pkg::ARC_TABLE[i]));
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(64'(ndb_pkg::ARC_TABLE[i]));
      end
    end
    if (x < 0) x = 0;
    if (x >= (64'sd1 <<< 27)) begin
      rng = ndb_pkg::RANGE_CAP;
    end else begin
      r = (64'(x) * 64'(ndb_pkg::INV_GAIN) + 64'h8000_0000) >> 32;
      rng = (r > 64'(ndb_pkg::RANGE_CAP)) ? ndb_pkg::RANGE_CAP : r[RW-1:0];
    end
    z = (z + 32768) >>> 16;
    if (z > 16384) z = 16384;
    if (z < -16384) z = -16384;
    brg = z[BW-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cc_q       = ndb_pkg::CENTER_COLUMN_RST;
      inv_q      = ndb_pkg::INVERSE_FOCAL_RST;
      min_q      = ndb_pkg::MIN_RANGE_RST;
      max_q      = ndb_pkg::MAX_RANGE_RST;
      best_rng   = ndb_pkg::RANGE_CAP;
      best_brg   = '0;
      have_point = 1'b0;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (ndb_pkg::cfg_reg_t'(cfg_index))
          ndb_pkg::REG_CENTER_COLUMN: cc_q  = cfg_data[15:0];
          ndb_pkg::REG_INVERSE_FOCAL: inv_q = cfg_data[23:0];
          ndb_pkg::REG_MIN_RANGE:     min_q = cfg_data[15:0];
          ndb_pkg::REG_MAX_RANGE:     max_q = cfg_data[15:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_pixel_valid && in_pixel_depth > min_q && in_pixel_depth < max_q) begin
          locate_point(in_pixel_depth, in_pixel_column, pt_rng, pt_brg);
          // later pixel wins on equal range
          if (!have_point || pt_rng <= best_rng) begin
            best_rng   = pt_rng;
            best_brg   = pt_brg;
            have_point = 1'b1;
          end
        end
        if (in_last_pixel) begin
          exp_res.rng = have_point ? best_rng : '0;
          exp_res.brg = have_point ? best_brg : '0;
          exp_res.fnd = have_point;
          due_results.insert(due_results.size(), exp_res);
          best_rng   = ndb_pkg::RANGE_CAP;
          best_brg   = '0;
          have_point = 1'b0;
        end
      end

      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with nothing expected: range %0d bearing %0d found %0d",
                   $time, out_nearest_range, out_nearest_bearing, out_found);
          fail_count = fail_count + 1;
        end else begin
          exp_res = due_results.pop_front();
          if (out_nearest_range !== exp_res.rng) begin
            $display("%0t: nearest_range expected %0d actual %0d",
                     $time, exp_res.rng, out_nearest_range);
            fail_count = fail_count + 1;
          end
          if (out_nearest_bearing !== exp_res.brg) begin
            $display("%0t: nearest_bearing expected %0d actual %0d",
                     $time, exp_res.brg, out_nearest_bearing);
            fail_count = fail_count + 1;
          end
          if (out_found !== exp_res.fnd) begin
            $display("%0t: found expected %0d actual %0d", $time, exp_res.fnd, out_found);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending_count = due_results.size();
  end

endmodule

### dv/tb_nearest_depth_bearing_in_box.sv
`timescale 1ns / 100ps

module tb_nearest_depth_bearing_in_box;

  localparam int CYCLE_LIMIT = 400000;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [ndb_pkg::DEPTH_W-1:0]          in_pixel_depth = '0;
  logic                                 in_pixel_valid = 1'b0;
  logic [ndb_pkg::COLUMN_W-1:0]         in_pixel_column = '0;
  logic                                 in_last_pixel = 1'b0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [ndb_pkg::RANGE_W-1:0]          out_nearest_range;
  logic signed [ndb_pkg::BEARING_W-1:0] out_nearest_bearing;
  logic                                 out_found;
  logic                                 cfg_we = 1'b0;
  logic [ndb_pkg::CFG_IDX_W-1:0]        cfg_index = ndb_pkg::REG_CENTER_COLUMN;
  logic [ndb_pkg::CFG_W-1:0]            cfg_data = '0;

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  logic no_idle = 1'b0;
  logic hold_req = 1'b0;

  int cc_cur = int'(ndb_pkg::CENTER_COLUMN_RST);
  int mn_cur = int'(ndb_pkg::MIN_RANGE_RST);
  int mx_cur = int'(ndb_pkg::MAX_RANGE_RST);

  always #1 clk = ~clk;

  nearest_depth_bearing_in_box uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_depth      (in_pixel_depth),
    .in_pixel_valid      (in_pixel_valid),
    .in_pixel_column     (in_pixel_column),
    .in_last_pixel       (in_last_pixel),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_nearest_range   (out_nearest_range),
    .out_nearest_bearing (out_nearest_bearing),
    .out_found           (out_found),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  ndb_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_depth      (in_pixel_depth),
    .in_pixel_valid      (in_pixel_valid),
    .in_pixel_column     (in_pixel_column),
    .in_last_pixel       (in_last_pixel),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_nearest_range   (out_nearest_range),
    .out_nearest_bearing (out_nearest_bearing),
    .out_found           (out_found),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending_count       (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_nearest_depth_bearing_in_box failed");
      $finish;
    end
  end

  // Result side: random stall per item, one long hold-off on request.
  initial begin : result_sink
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      n = no_idle ? 0 : int'($urandom_range(0, 10));
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_pixel(input logic [15:0] d, input logic v, input logic [11:0] col,
                            input logic lst);
    int gap;
    gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10)));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pixel_depth  <= d;
    in_pixel_valid  <= v;
    in_pixel_column <= col;
    in_last_pixel   <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_pixel(input logic lst);
    logic [15:0] d;
    logic [11:0] col;
    int sel;
    int c;
    sel = int'($urandom_range(0, 9));
    if (sel < 7 && mx_cur > mn_cur + 1) begin
      d = 16'($urandom_range(mn_cur + 1, mx_cur - 1));
    end else if (sel < 8) begin
      case ($urandom_range(0, 5))
        0: d = 16'(mn_cur);
        1: d = 16'(mx_cur);
        2: d = 16'(mn_cur + 1);
        3: d = 16'(mx_cur - 1);
        4: d = 16'd0;
        default: d = 16'hFFFF;
      endcase
    end else begin
      d = 16'($urandom);
    end
    if ($urandom_range(0, 1) == 1) begin
      col = 12'($urandom);
    end else begin
      // stay near the optical center
      c = cc_cur / 16 + int'($urandom_range(0, 40)) - 20;
      if (c < 0) c = 0;
      if (c > 4095) c = 4095;
      col = 12'(c);
    end
    send_pixel(d, $urandom_range(0, 9) != 0, col, lst);
  endtask

  task automatic run_boxes(input int n_items, input int max_len);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if (max_len > 12 && $urandom_range(0, 9) == 0) len = int'($urandom_range(13, max_len));
      else len = int'($urandom_range(1, (max_len < 8) ? max_len : 8));
      for (int k = 0; k < len; k++) send_random_pixel(k == len - 1);
      sent += len;
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // drain pixels still in flight that produce no result
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input ndb_pkg::cfg_reg_t idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] cc, input logic [23:0] inv,
                            input logic [15:0] mn, input logic [15:0] mx);
    in_valid <= 1'b0;
    wait_idle();
    // junk in the unused upper bits of the narrow registers
    write_reg(ndb_pkg::REG_CENTER_COLUMN, {8'($urandom), cc});
    write_reg(ndb_pkg::REG_INVERSE_FOCAL, inv);
    write_reg(ndb_pkg::REG_MIN_RANGE, {8'($urandom), mn});
    write_reg(ndb_pkg::REG_MAX_RANGE, {8'($urandom), mx});
    cfg_we <= 1'b0;
    cc_cur = int'(cc);
    mn_cur = int'(mn);
    mx_cur = int'(mx);
  endtask

  task automatic random_config();
    logic [15:0] mn;
    logic [23:0] inv;
    mn  = 16'($urandom_range(0, 2000));
    inv = ($urandom_range(0, 1) == 1) ? 24'($urandom_range(1, 100000)) :
                                        24'($urandom_range(1, 24'hFFFFFF));
    set_config(16'($urandom_range(0, 65535)), inv, mn,
               16'($urandom_range(32'(mn) + 2, 65535)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // range limits, invalid depth, column extremes, column on the center
    send_pixel(16'd0,     1'b1, 12'd0,    1'b0);
    send_pixel(16'd10,    1'b1, 12'd320,  1'b0);
    send_pixel(16'd10000, 1'b1, 12'd320,  1'b0);
    send_pixel(16'd11,    1'b1, 12'd4095, 1'b0);
    send_pixel(16'd9999,  1'b1, 12'd0,    1'b0);
    send_pixel(16'hFFFF,  1'b1, 12'd4095, 1'b0);
    send_pixel(16'd500,   1'b0, 12'd320,  1'b0);
    send_pixel(16'd500,   1'b1, 12'd320,  1'b1);
    // empty boxes
    send_pixel(16'd5000,  1'b0, 12'd100,  1'b1);
    send_pixel(16'd10,    1'b1, 12'd320,  1'b1);
    // equal ranges on both sides of the center: later pixel wins
    send_pixel(16'd2000,  1'b1, 12'd300,  1'b0);
    send_pixel(16'd2000,  1'b1, 12'd340,  1'b1);
    send_pixel(16'd2000,  1'b1, 12'd340,  1'b0);
    send_pixel(16'd2000,  1'b1, 12'd300,  1'b1);
    // nearer first, box closed by a pixel that does not count
    send_pixel(16'd1000,  1'b1, 12'd320,  1'b0);
    send_pixel(16'd3000,  1'b1, 12'd320,  1'b0);
    send_pixel(16'hFFFF,  1'b1, 12'd320,  1'b1);
    send_pixel(16'd9999,  1'b1, 12'd4095, 1'b1);
    send_pixel(16'd11,    1'b1, 12'd0,    1'b1);

    run_boxes(200, 40);
    // hold the sender until every result is out
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    run_boxes(100, 40);

    // lateral offset large enough to saturate the range
    set_config(16'd0, 24'hFFFFFF, 16'd0, 16'hFFFF);
    run_boxes(200, 40);
    set_config(16'hFFFF, 24'd1, 16'd0, 16'hFFFF);
    run_boxes(200, 40);
    // zero focal reciprocal
    set_config(16'($urandom_range(0, 65535)), 24'd0, 16'd10, 16'd10000);
    run_boxes(100, 40);
    // inverted or touching limits
    set_config(16'd5120, 24'd27962, 16'd5000, 16'd5001);
    run_boxes(80, 40);
    set_config(16'd5120, 24'd27962, 16'hFFFF, 16'd0);
    run_boxes(60, 40);

    repeat (4) begin
      random_config();
      run_boxes(80, 40);
      no_idle = 1'b1;
      run_boxes(40, 40);
      no_idle = 1'b0;
    end

    // long receiver hold-off: short boxes keep coming until the input stalls
    random_config();
    hold_req = 1'b1;
    run_boxes(60, 2);
    run_boxes(90, 40);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_nearest_depth_bearing_in_box passed");
    end else begin
      $display("tb_nearest_depth_bearing_in_box failed");
    end
    $finish;
  end

endmodule

### nearest_depth_bearing_in_box.f
hdl/ndb_pkg.sv
hdl/ndb_front.sv
hdl/ndb_cordic_cell.sv
hdl/ndb_track.sv
hdl/nearest_depth_bearing_in_box.sv
dv/ndb_checker.sv
dv/tb_nearest_depth_bearing_in_box.sv
